// ===== src/rltm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rltm_pkg
// Shared types and codes for the run-length tape machine: transaction
// payloads, function codes, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package rltm_pkg;

  // function codes carried by an input transaction
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // instruction opcodes
  localparam logic [2:0] OP_RIGHT = 3'd0;
  localparam logic [2:0] OP_LEFT  = 3'd1;
  localparam logic [2:0] OP_PLUS  = 3'd2;
  localparam logic [2:0] OP_MINUS = 3'd3;
  localparam logic [2:0] OP_OUT   = 3'd4;
  localparam logic [2:0] OP_IN    = 3'd5;
  localparam logic [2:0] OP_OPEN  = 3'd6;
  localparam logic [2:0] OP_CLOSE = 3'd7;

  // result status codes
  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_STEP = 3'd1;
  localparam logic [2:0] STAT_OUT  = 3'd2;
  localparam logic [2:0] STAT_HALT = 3'd3;
  localparam logic [2:0] STAT_FULL = 3'd4;

  // width of one program store entry: {op, count}
  localparam int INSN_W = 11;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] op;
    logic [7:0] count;
    logic [7:0] in_byte;
  } rltm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [7:0]  out_repeat;
    logic [12:0] next_pc;
  } rltm_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } rltm_state_t;

endpackage
`default_nettype wire

// ===== src/rltm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rltm_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module rltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/run_length_tape_machine_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_tape_machine_step
// Run-length tape language interpreter: append, step and clear transactions
// against a program store RAM and a byte tape RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the transaction is taken on a clock
//   edge with start high and busy low. Output: every transaction yields one
//   result on the result port, flagged by done for a single cycle. The
//   receiver cannot stall; a result must be captured when done is high.
// Sequence and throughput:
//   append, unused function and step past the end: result in the cycle after
//   acceptance, and a new transaction can be taken every cycle.
//   step: the program entry and tape cell are read together on acceptance, then
//   ST_FETCH writes the tape cell back and registers the result. A taken
//   bracket instead enters ST_SCAN, which reads one program entry at a time
//   until a match or the end of the program, bounded by the program length.
//   clear: result in the cycle after acceptance, then busy while the tape
//   RAM is zeroed one cell per cycle.
// Reset:
//   rst clears the counters and runs the same tape zeroing pass (busy high).
//   The program store is not cleared.
// ----------------------------------------------------------------------------
module run_length_tape_machine_step #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_CELLS = 32768
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire rltm_pkg::rltm_in_t item,
  output logic                    done,
  output rltm_pkg::rltm_out_t     result
);

  import rltm_pkg::*;

  localparam int AW   = $clog2(PROG_DEPTH);
  localparam int PC_W = $clog2(PROG_DEPTH + 1);
  localparam int TP_W = $clog2(TAPE_CELLS);

  rltm_state_t state, state_next;

  logic [PC_W-1:0] len, len_next;
  logic [PC_W-1:0] pc, pc_next;
  logic [TP_W-1:0] tp, tp_next;
  logic [TP_W-1:0] clr_idx, clr_idx_next;
  logic [PC_W-1:0] scan_j, scan_j_next;
  logic [PC_W-1:0] scan_jd, scan_jd_next;
  logic [PC_W-1:0] depth, depth_next;
  logic            scan_pend, scan_pend_next;
  logic            scan_more, scan_more_next;
  logic            scan_fwd, scan_fwd_next;
  logic [7:0]      in_q, in_q_next;
  logic            done_next;
  rltm_out_t       result_next;

  logic              prog_we;
  logic [AW-1:0]     prog_waddr, prog_raddr;
  logic [INSN_W-1:0] prog_wdata, prog_rdata;
  logic              tape_we;
  logic [TP_W-1:0]   tape_waddr;
  logic [7:0]        tape_wdata, tape_rdata;

  logic            acc;
  logic [2:0]      cur_op;
  logic [7:0]      cur_cnt;
  logic [7:0]      cur_byte;
  logic            take_open, take_close;
  logic [PC_W-1:0] pc_inc, pc_dec, scan_j_inc;
  logic [TP_W:0]   cnt_ext, tp_sum, tp_diff, tp_right, tp_left;
  logic [2:0]      nest_op, match_op;
  logic            scan_hit, scan_end;

  function automatic logic [12:0] pc13(input logic [PC_W-1:0] v);
    logic [PC_W+12:0] e;
    e = {13'b0, v};
    return e[12:0];
  endfunction

  rltm_ram #(
    .WIDTH (INSN_W),
    .DEPTH (PROG_DEPTH)
  ) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  rltm_ram #(
    .WIDTH (8),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (tp),
    .rdata (tape_rdata)
  );

  assign busy = (state != ST_IDLE);
  assign acc  = start && !busy;

  assign cur_op   = prog_rdata[10:8];
  assign cur_cnt  = prog_rdata[7:0];
  assign cur_byte = tape_rdata;

  assign take_open  = (cur_op == OP_OPEN) && (cur_byte == 8'd0);
  assign take_close = (cur_op == OP_CLOSE) && (cur_byte != 8'd0);

  assign pc_inc     = pc + 1'b1;
  assign pc_dec     = pc - 1'b1;
  assign scan_j_inc = scan_j + 1'b1;

  // pointer arithmetic modulo TAPE_CELLS; count is always below TAPE_CELLS
  assign cnt_ext  = {{(TP_W - 7){1'b0}}, cur_cnt};
  assign tp_sum   = {1'b0, tp} + cnt_ext;
  assign tp_diff  = {1'b0, tp} - cnt_ext;
  assign tp_right = (tp_sum >= (TP_W + 1)'(TAPE_CELLS)) ?
                    tp_sum - (TP_W + 1)'(TAPE_CELLS) : tp_sum;
  assign tp_left  = tp_diff[TP_W] ? tp_diff + (TP_W + 1)'(TAPE_CELLS) : tp_diff;

  // forward scan nests on open and stops on close; backward the reverse
  assign nest_op  = scan_fwd ? OP_OPEN : OP_CLOSE;
  assign match_op = scan_fwd ? OP_CLOSE : OP_OPEN;
  assign scan_hit = scan_pend && (prog_rdata[10:8] == match_op) && (depth == '0);
  assign scan_end = !scan_pend && !scan_more;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (item.func)
            FUNC_STEP: begin
              if (pc < len) begin
                state_next = ST_FETCH;
              end
            end
            FUNC_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        if (take_open || take_close) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_idx == TP_W'(TAPE_CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    len_next       = len;
    pc_next        = pc;
    tp_next        = tp;
    clr_idx_next   = clr_idx;
    scan_j_next    = scan_j;
    scan_jd_next   = scan_jd;
    depth_next     = depth;
    scan_pend_next = scan_pend;
    scan_more_next = scan_more;
    scan_fwd_next  = scan_fwd;
    in_q_next      = in_q;
    done_next      = 1'b0;
    result_next    = result;

    prog_we    = 1'b0;
    prog_waddr = len[AW-1:0];
    prog_wdata = {item.op, item.count};
    prog_raddr = pc[AW-1:0];
    tape_we    = 1'b0;
    tape_waddr = tp;
    tape_wdata = 8'd0;

    case (state)
      ST_IDLE: begin
        if (acc) begin
          in_q_next = item.in_byte;
          case (item.func)
            FUNC_APPEND: begin
              done_next = 1'b1;
              if (len == PC_W'(PROG_DEPTH)) begin
                result_next = '{STAT_FULL, 8'd0, 8'd0, pc13(pc)};
              end else begin
                prog_we     = 1'b1;
                len_next    = len + 1'b1;
                result_next = '{STAT_DONE, 8'd0, 8'd0, pc13(pc)};
              end
            end
            FUNC_STEP: begin
              // entry and cell reads are issued here; past the end answer now
              if (pc >= len) begin
                done_next   = 1'b1;
                result_next = '{STAT_HALT, 8'd0, 8'd0, pc13(pc)};
              end
            end
            FUNC_CLEAR: begin
              len_next     = '0;
              pc_next      = '0;
              tp_next      = '0;
              clr_idx_next = '0;
              done_next    = 1'b1;
              result_next  = '{STAT_DONE, 8'd0, 8'd0, 13'd0};
            end
            default: begin
              done_next   = 1'b1;
              result_next = '{STAT_DONE, 8'd0, 8'd0, pc13(pc)};
            end
          endcase
        end
      end

      ST_FETCH: begin
        pc_next     = pc_inc;
        result_next = '{STAT_STEP, 8'd0, 8'd0, pc13(pc_inc)};
        done_next   = 1'b1;
        case (cur_op)
          OP_RIGHT: tp_next = tp_right[TP_W-1:0];
          OP_LEFT:  tp_next = tp_left[TP_W-1:0];
          OP_PLUS: begin
            tape_we    = 1'b1;
            tape_wdata = cur_byte + cur_cnt;
          end
          OP_MINUS: begin
            tape_we    = 1'b1;
            tape_wdata = cur_byte - cur_cnt;
          end
          OP_OUT: result_next = '{STAT_OUT, cur_byte, cur_cnt, pc13(pc_inc)};
          OP_IN: begin
            tape_we    = 1'b1;
            tape_wdata = in_q;
          end
          default: begin
            // taken bracket: hold the result and start the scan
            if (take_open || take_close) begin
              done_next      = 1'b0;
              pc_next        = pc;
              depth_next     = '0;
              scan_pend_next = 1'b0;
              scan_fwd_next  = take_open;
              if (take_open) begin
                scan_j_next    = pc_inc;
                scan_more_next = (pc_inc < len);
              end else begin
                scan_j_next    = pc_dec;
                scan_more_next = (pc != '0);
              end
            end
          end
        endcase
      end

      ST_SCAN: begin
        prog_raddr = scan_j[AW-1:0];
        if (scan_hit) begin
          pc_next     = scan_jd + 1'b1;
          done_next   = 1'b1;
          result_next = '{STAT_STEP, 8'd0, 8'd0, pc13(scan_jd + 1'b1)};
        end else if (scan_end) begin
          pc_next     = pc_inc;
          done_next   = 1'b1;
          result_next = '{STAT_STEP, 8'd0, 8'd0, pc13(pc_inc)};
        end else begin
          if (scan_pend) begin
            if (prog_rdata[10:8] == nest_op) begin
              depth_next = depth + 1'b1;
            end else if (prog_rdata[10:8] == match_op) begin
              depth_next = depth - 1'b1;
            end
          end
          // issue the next entry while the previous one is evaluated
          scan_pend_next = scan_more;
          if (scan_more) begin
            scan_jd_next = scan_j;
            if (scan_fwd) begin
              scan_j_next    = scan_j_inc;
              scan_more_next = (scan_j_inc < len);
            end else begin
              scan_j_next    = scan_j - 1'b1;
              scan_more_next = (scan_j != '0);
            end
          end
        end
      end

      ST_CLEAR: begin
        tape_we      = 1'b1;
        tape_waddr   = clr_idx;
        tape_wdata   = 8'd0;
        clr_idx_next = clr_idx + 1'b1;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      len       <= '0;
      pc        <= '0;
      tp        <= '0;
      clr_idx   <= '0;
      scan_pend <= 1'b0;
      scan_more <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      pc        <= pc_next;
      tp        <= tp_next;
      clr_idx   <= clr_idx_next;
      scan_pend <= scan_pend_next;
      scan_more <= scan_more_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_j   <= scan_j_next;
    scan_jd  <= scan_jd_next;
    depth    <= depth_next;
    scan_fwd <= scan_fwd_next;
    in_q     <= in_q_next;
    result   <= result_next;
  end

  a_append_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func == FUNC_APPEND) |=> done)
    else $error("append transaction produced no result");

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= len)
    else $error("program counter beyond program length");

  a_len_in_store: assert property (@(posedge clk) disable iff (rst)
    len <= PC_W'(PROG_DEPTH))
    else $error("program length beyond store depth");

  a_tp_on_tape: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tp} < (TP_W + 1)'(TAPE_CELLS))
    else $error("tape pointer off the tape");

endmodule
`default_nettype wire

// ===== tb/tape_machine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_checker
// Watches the command and result channels of the run-length tape machine,
// interprets every accepted transaction against its own copy of the program
// store and tape, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tape_machine_checker #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_CELLS = 32768
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire rltm_pkg::rltm_in_t item,
  input  wire logic               done,
  input  wire rltm_pkg::rltm_out_t result,
  output int unsigned             mismatches,
  output int unsigned             answers_owed
);
  import rltm_pkg::*;

  logic [INSN_W-1:0] insn_mem [PROG_DEPTH];
  logic [7:0]        cell_mem [TAPE_CELLS];
  int unsigned       insn_count;
  int unsigned       pc;
  int unsigned       head;

  rltm_out_t   answers_due[$];
  int unsigned bad = 0;
  int unsigned owed = 0;

  assign mismatches   = bad;
  assign answers_owed = owed;

  function automatic void wipe_run_state();
    insn_count = 0;
    pc         = 0;
    head       = 0;
    for (int i = 0; i < TAPE_CELLS; i++) cell_mem[i] = 8'h00;
  endfunction

  // Interpret one transaction and return the result it should produce.
  function automatic rltm_out_t interpret_item(rltm_in_t it);
    rltm_out_t   r;
    logic [2:0]  iop;
    logic [7:0]  icnt;
    logic [2:0]  scan_op;
    int unsigned nxt;
    int unsigned depth;
    int unsigned j;
    bit          hit;
    r = '0;
    r.status = STAT_DONE;
    case (it.func)
      FUNC_APPEND: begin
        if (insn_count >= PROG_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          insn_mem[insn_count] = {it.op, it.count};
          insn_count++;
        end
      end
      FUNC_STEP: begin
        if (pc >= insn_count) begin
          r.status = STAT_HALT;
        end else begin
          iop      = insn_mem[pc][10:8];
          icnt     = insn_mem[pc][7:0];
          nxt      = pc + 1;
          r.status = STAT_STEP;
          case (iop)
            OP_RIGHT: head = (head + icnt) % TAPE_CELLS;
            OP_LEFT:  head = (head + TAPE_CELLS - icnt) % TAPE_CELLS;
            OP_PLUS:  cell_mem[head] = cell_mem[head] + icnt;
            OP_MINUS: cell_mem[head] = cell_mem[head] - icnt;
            OP_OUT: begin
              r.status     = STAT_OUT;
              r.out_byte   = cell_mem[head];
              r.out_repeat = icnt;
            end
            OP_IN:    cell_mem[head] = it.in_byte;
            OP_OPEN: begin
              if (cell_mem[head] == 8'h00) begin
                depth = 0;
                hit   = 1'b0;
                for (j = pc + 1; j < insn_count && !hit; j++) begin
                  scan_op = insn_mem[j][10:8];
                  if (scan_op == OP_OPEN) begin
                    depth++;
                  end else if (scan_op == OP_CLOSE) begin
                    if (depth == 0) begin
                      nxt = j + 1;
                      hit = 1'b1;
                    end else begin
                      depth--;
                    end
                  end
                end
              end
            end
            default: begin
              // close: walk back as far as entry 0
              if (cell_mem[head] != 8'h00) begin
                depth = 0;
                hit   = 1'b0;
                j     = pc;
                while (j > 0 && !hit) begin
                  j--;
                  scan_op = insn_mem[j][10:8];
                  if (scan_op == OP_CLOSE) begin
                    depth++;
                  end else if (scan_op == OP_OPEN) begin
                    if (depth == 0) begin
                      nxt = j + 1;
                      hit = 1'b1;
                    end else begin
                      depth--;
                    end
                  end
                end
              end
            end
          endcase
          pc = nxt;
        end
      end
      FUNC_CLEAR: wipe_run_state();
      default: ;
    endcase
    r.next_pc = pc[12:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rltm_out_t want;
    if (rst) begin
      wipe_run_state();
      answers_due.delete();
    end else begin
      // check before queueing: a result never belongs to the transaction
      // taken on the same edge
      if (done) begin
        if (answers_due.size() == 0) begin
          $error("result with no transaction pending: status %0d next_pc %0d",
                 result.status, result.next_pc);
          bad++;
        end else begin
          want = answers_due.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            bad++;
          end
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, result.out_byte);
            bad++;
          end
          if (result.out_repeat !== want.out_repeat) begin
            $error("out_repeat: expected %0d, got %0d", want.out_repeat,
                   result.out_repeat);
            bad++;
          end
          if (result.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0d, got %0d", want.next_pc, result.next_pc);
            bad++;
          end
        end
      end
      if (start && !busy) answers_due.push_back(interpret_item(item));
    end
    owed <= answers_due.size();
  end

endmodule

// ===== tb/run_length_tape_machine_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_tape_machine_step_test
// Drives append, step and clear transactions into the tape machine: a short
// directed program for the corner cases, then random bracketed programs with
// random idle gaps, and reports the verdict.
// ----------------------------------------------------------------------------
module run_length_tape_machine_step_test;
  import rltm_pkg::*;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_CELLS = 32768;
  localparam int ITEM_GOAL  = 1900;

  // function code the block leaves unused
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  rltm_in_t  item = '0;
  logic      busy;
  logic      done;
  rltm_out_t result;

  int unsigned mismatches;
  int unsigned answers_owed;

  int unsigned items_sent = 0;
  int unsigned prog_len = 0;
  bit          quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  run_length_tape_machine_step #(
    .PROG_DEPTH(PROG_DEPTH),
    .TAPE_CELLS(TAPE_CELLS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  tape_machine_checker #(
    .PROG_DEPTH(PROG_DEPTH),
    .TAPE_CELLS(TAPE_CELLS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .answers_owed(answers_owed)
  );

  // Present one transaction and hold it until the edge that takes it.
  task automatic send(logic [1:0] func, logic [2:0] op, logic [7:0] cnt,
                      logic [7:0] in_byte);
    rltm_in_t it;
    int       r;
    int       gap;
    it.func    = func;
    it.op      = op;
    it.count   = cnt;
    it.in_byte = in_byte;
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r < 55)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 60);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic append(logic [2:0] op, logic [7:0] cnt);
    send(FUNC_APPEND, op, cnt, 8'($urandom_range(0, 255)));
    prog_len++;
  endtask

  task automatic step(logic [7:0] in_byte);
    send(FUNC_STEP, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), in_byte);
  endtask

  task automatic wipe();
    send(FUNC_CLEAR, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
    prog_len = 0;
  endtask

  // Hold off until every result owed has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_count();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0)     return 8'd0;
    else if (r < 4) return 8'($urandom_range(1, 3));
    else            return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] plain_op();
    return 3'($urandom_range(OP_RIGHT, OP_IN));
  endfunction

  initial begin : stimulus
    int depth;
    int r;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty program, unused code, every opcode and count extremes
    step(8'h00);
    send(FUNC_UNUSED, 3'h7, 8'hFF, 8'hFF);
    append(OP_OPEN, 8'd255);
    append(OP_IN, 8'd1);
    append(OP_PLUS, 8'd255);
    append(OP_OUT, 8'd255);
    append(OP_MINUS, 8'd0);
    append(OP_LEFT, 8'd255);
    append(OP_OUT, 8'd0);
    step(8'h00);            // open with no partner: just advance
    step(8'h02);
    step(8'h00);
    step(8'h00);            // out byte 1, repeat 255
    step(8'h00);
    step(8'h00);            // pointer wraps below zero
    step(8'h00);            // out with zero repeat
    append(OP_RIGHT, 8'd255);
    append(OP_CLOSE, 8'd0);
    step(8'h00);
    step(8'h00);            // close scans back to entry 0
    step(8'h00);
    wipe();
    step(8'hFF);
    drain();

    // random bracketed programs
    while (items_sent < ITEM_GOAL) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (prog_len > 120 || $urandom_range(0, 11) == 0) wipe();
      depth = 0;
      n = $urandom_range(2, 14);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          append(OP_OPEN, rand_count());
          depth++;
        end else if (r < 4 && depth > 0) begin
          append(OP_CLOSE, rand_count());
          depth--;
        end else begin
          append(plain_op(), rand_count());
        end
      end
      // mostly close what is open; now and then leave it dangling or overclose
      r = $urandom_range(0, 5);
      if (r == 0)      append(OP_CLOSE, rand_count());
      else if (r != 1) repeat (depth) append(OP_CLOSE, rand_count());
      n = $urandom_range(4, 30);
      repeat (n) begin
        if ($urandom_range(0, 24) == 0)
          send(FUNC_UNUSED, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
        else
          step(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    quiet = 1'b0;

    drain();
    for (int k = 0; k < TAPE_CELLS + 64 && busy; k++) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("run_length_tape_machine_step_test: clean");
    end else begin
      $display("run_length_tape_machine_step_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("run_length_tape_machine_step_test: errors");
    $finish;
  end

endmodule

// ===== run_length_tape_machine_step.f =====
src/rltm_pkg.sv
src/rltm_ram.sv
src/run_length_tape_machine_step.sv
tb/tape_machine_checker.sv
tb/run_length_tape_machine_step_test.sv
